### rtl/hcd_pkg.sv
package hcd_pkg;

  // Width of the chunk size counter; a size that needs more bits is an error.
  localparam int SIZE_BITS = 32;

  // Result status codes.
  localparam logic [1:0] ST_FRAME = 2'd0;
  localparam logic [1:0] ST_DATA  = 2'd1;
  localparam logic [1:0] ST_END   = 2'd2;
  localparam logic [1:0] ST_ERR   = 2'd3;

  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_SEMI = 8'h3b;

  // One classified input word, handed from the front to the back.
  typedef struct packed {
    logic [7:0] raw;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       ws;
    logic       semi;
    logic       cr;
    logic       lf;
  } class_t;

  function automatic class_t classify(input logic [7:0] c);
    class_t k;
    k.raw     = c;
    k.hex_ok  = 1'b0;
    k.hex_val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      k.hex_ok  = 1'b1;
      k.hex_val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      k.hex_ok  = 1'b1;
      k.hex_val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      k.hex_ok  = 1'b1;
      k.hex_val = 4'(c - 8'h37);
    end
    // space, tab, LF, VT, FF, CR
    k.ws   = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
    k.semi = (c == CH_SEMI);
    k.cr   = (c == CH_CR);
    k.lf   = (c == CH_LF);
    return k;
  endfunction

endpackage

### rtl/hcd_in_if.sv
interface hcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

### rtl/hcd_out_if.sv
interface hcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] status;

  modport source (output valid, output data_byte, output status, input ready);
  modport sink (input valid, input data_byte, input status, output ready);
endinterface

### rtl/hcd_front.sv
module hcd_front (
  input  logic            clk,
  input  logic            rst,
  hcd_in_if.sink          body,
  output logic            push,
  output hcd_pkg::class_t push_word,
  input  logic            q_full
);
  import hcd_pkg::*;

  logic   held;
  class_t word;

  assign push       = held && !q_full;
  assign push_word  = word;
  assign body.ready = !held || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (body.valid && body.ready) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  // Classify on the way in.
  always_ff @(posedge clk) begin
    if (body.valid && body.ready) begin
      word <= classify(body.in_byte);
    end
  end

endmodule

### rtl/hcd_queue.sv
module hcd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hcd_pkg::class_t push_word,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output hcd_pkg::class_t pop_word
);
  import hcd_pkg::*;

  class_t     slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign pop_word = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_word;
    end
  end

endmodule

### rtl/hcd_back.sv
module hcd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            nonempty,
  input  hcd_pkg::class_t word,
  output logic            pop,
  hcd_out_if.source       result
);
  import hcd_pkg::*;

  localparam logic [2:0] PH_SIZE    = 3'd0;
  localparam logic [2:0] PH_EXT     = 3'd1;
  localparam logic [2:0] PH_SIZE_LF = 3'd2;
  localparam logic [2:0] PH_DATA    = 3'd3;
  localparam logic [2:0] PH_DATA_CR = 3'd4;
  localparam logic [2:0] PH_DATA_LF = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;
  localparam logic [2:0] PH_ERROR   = 3'd7;

  logic [2:0]           phase, phase_next;
  logic [SIZE_BITS-1:0] remaining, remaining_next;
  logic                 seen, seen_next;
  logic [1:0]           st_next;
  logic                 out_valid;
  logic [7:0]           data_byte;
  logic [1:0]           status;

  assign pop              = nonempty && (!out_valid || result.ready);
  assign result.valid     = out_valid;
  assign result.data_byte = data_byte;
  assign result.status    = status;

  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    seen_next      = seen;
    st_next        = ST_FRAME;
    case (phase)
      PH_SIZE: begin
        if (word.hex_ok) begin
          if (remaining[SIZE_BITS-1 -: 4] != 4'd0) begin
            phase_next = PH_ERROR;
            st_next    = ST_ERR;
          end else begin
            remaining_next = {remaining[SIZE_BITS-5:0], word.hex_val};
            seen_next      = 1'b1;
          end
        end else if (!seen) begin
          if (!word.ws) begin
            phase_next = PH_ERROR;
            st_next    = ST_ERR;
          end
        end else if (word.semi) begin
          phase_next = PH_EXT;
        end else if (word.cr) begin
          phase_next = PH_SIZE_LF;
        end else begin
          phase_next = PH_ERROR;
          st_next    = ST_ERR;
        end
      end
      PH_EXT: begin
        if (word.cr) begin
          phase_next = PH_SIZE_LF;
        end
      end
      PH_SIZE_LF: begin
        if (!word.lf) begin
          phase_next = PH_ERROR;
          st_next    = ST_ERR;
        end else begin
          seen_next = 1'b0;
          if (remaining == '0) begin
            phase_next = PH_DONE;
            st_next    = ST_END;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        remaining_next = remaining - SIZE_BITS'(1);
        st_next        = ST_DATA;
        if (remaining == SIZE_BITS'(1)) begin
          phase_next = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (word.cr) begin
          phase_next = PH_DATA_LF;
        end else begin
          phase_next = PH_ERROR;
          st_next    = ST_ERR;
        end
      end
      PH_DATA_LF: begin
        if (word.lf) begin
          phase_next     = PH_SIZE;
          remaining_next = '0;
          seen_next      = 1'b0;
        end else begin
          phase_next = PH_ERROR;
          st_next    = ST_ERR;
        end
      end
      PH_DONE: begin
        st_next = ST_END;
      end
      default: begin
        phase_next = PH_ERROR;
        st_next    = ST_ERR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SIZE;
      remaining <= '0;
      seen      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        phase     <= phase_next;
        remaining <= remaining_next;
        seen      <= seen_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status    <= st_next;
      data_byte <= (st_next == ST_DATA) ? word.raw : 8'd0;
    end
  end

endmodule

### rtl/http_chunked_body_decoder.sv
// HTTP/1.1 chunked body decoder.
//
// body (sink): one raw byte of the chunked body per word, field in_byte.
// result (source): one word for every byte taken, in order, with status
//   0 framing byte consumed, 1 payload byte (in data_byte), 2 body ended,
//   3 error; data_byte is zero unless status is 1.
// Both channels move a word at a rising edge where valid and ready are high.
//
// Throughput: one byte per cycle while the receiver keeps result.ready high,
// set by the phase update in the back end. Each byte passes through the front
// register, then the queue, then the output register, before its result word
// is valid.
// A stalled receiver only holds the output register; the queue and the front
// register keep taking bytes until they fill, then body.ready drops.
// Reset (rst, synchronous): empties the pipeline and returns the parser to
// waiting for a chunk size. Errors stay until reset; after the last chunk
// every byte answers "body ended".
module http_chunked_body_decoder (
  input  logic  clk,
  input  logic  rst,
  hcd_in_if.sink     body,
  hcd_out_if.source  result
);
  import hcd_pkg::*;

  logic   push;
  class_t push_word;
  logic   q_full;
  logic   pop;
  logic   q_nonempty;
  class_t pop_word;

  // Front: take and classify bytes.
  hcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .body      (body),
    .push      (push),
    .push_word (push_word),
    .q_full    (q_full)
  );

  // Decouple the two halves so each can stall on its own.
  hcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (pop),
    .nonempty  (q_nonempty),
    .pop_word  (pop_word)
  );

  // Back: run the chunk framing and drive results.
  hcd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (q_nonempty),
    .word     (pop_word),
    .pop      (pop),
    .result   (result)
  );

endmodule

### verif/hcd_result_checker.sv
`timescale 1ns / 100ps

module hcd_result_checker (
  input  logic        clk,
  input  logic        rst,
  hcd_in_if           body,
  hcd_out_if          result,
  output int unsigned fail_count,
  output int unsigned words_owed
);
  import hcd_pkg::*;

  typedef enum logic [2:0] {
    P_SIZE,
    P_EXT,
    P_SIZE_LF,
    P_DATA,
    P_DATA_CR,
    P_DATA_LF,
    P_DONE,
    P_ERROR
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] status;
  } decoded_t;

  parse_phase_t phase;
  logic [63:0]  size_left;
  logic         got_digit;
  decoded_t     owed_q[$];

  function automatic logic [1:0] trip();
    phase = P_ERROR;
    return ST_ERR;
  endfunction

  // Advance the parser by one byte and return the word it should produce.
  function automatic decoded_t decode_byte(input logic [7:0] c);
    decoded_t   w;
    logic [3:0] nib;
    logic       is_hex;
    logic       is_space;
    w.data_byte = 8'h00;
    w.status    = ST_FRAME;
    is_hex      = 1'b1;
    nib         = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) nib = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) nib = 4'(c - 8'h61 + 8'd10);
    else if (c >= 8'h41 && c <= 8'h46) nib = 4'(c - 8'h41 + 8'd10);
    else is_hex = 1'b0;
    is_space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0b) ||
               (c == 8'h0c) || (c == 8'h0d);
    case (phase)
      P_SIZE: begin
        if (is_hex) begin
          if ((size_left >> (SIZE_BITS - 4)) != 64'd0) begin
            w.status = trip();
          end else begin
            size_left = (size_left << 4) | 64'(nib);
            got_digit = 1'b1;
          end
        end else if (!got_digit) begin
          if (!is_space) w.status = trip();
        end else if (c == CH_SEMI) begin
          phase = P_EXT;
        end else if (c == CH_CR) begin
          phase = P_SIZE_LF;
        end else begin
          w.status = trip();
        end
      end
      P_EXT: begin
        if (c == CH_CR) phase = P_SIZE_LF;
      end
      P_SIZE_LF: begin
        if (c != CH_LF) begin
          w.status = trip();
        end else begin
          got_digit = 1'b0;
          if (size_left == 64'd0) begin
            phase    = P_DONE;
            w.status = ST_END;
          end else begin
            phase = P_DATA;
          end
        end
      end
      P_DATA: begin
        size_left = size_left - 64'd1;
        if (size_left == 64'd0) phase = P_DATA_CR;
        w.status    = ST_DATA;
        w.data_byte = c;
      end
      P_DATA_CR: begin
        if (c != CH_CR) w.status = trip();
        else phase = P_DATA_LF;
      end
      P_DATA_LF: begin
        if (c != CH_LF) begin
          w.status = trip();
        end else begin
          phase     = P_SIZE;
          size_left = 64'd0;
          got_digit = 1'b0;
        end
      end
      P_DONE: w.status = ST_END;
      default: w.status = trip();
    endcase
    return w;
  endfunction

  always @(posedge clk) begin
    decoded_t want;
    int       errs;
    errs = 0;
    if (rst) begin
      phase     = P_SIZE;
      size_left = 64'd0;
      got_digit = 1'b0;
      owed_q.delete();
      fail_count <= 0;
    end else begin
      // Compare first: a byte taken at this edge cannot have its word out yet.
      if (result.valid && result.ready) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result word: status %0d data_byte %02h",
                 result.status, result.data_byte);
          errs++;
        end else begin
          want = owed_q.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            errs++;
          end
          if (result.data_byte !== want.data_byte) begin
            $error("data_byte: expected %02h, got %02h", want.data_byte, result.data_byte);
            errs++;
          end
        end
      end
      if (body.valid && body.ready) owed_q.push_back(decode_byte(body.in_byte));
      fail_count <= fail_count + errs;
    end
    words_owed <= owed_q.size();
  end

endmodule

### verif/tb_http_chunked_body_decoder.sv
`timescale 1ns / 100ps

module tb_http_chunked_body_decoder;
  import hcd_pkg::*;

  // Characters the stream builder needs beyond those in the package.
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_VT   = 8'h0b;
  localparam logic [7:0] CH_FF   = 8'h0c;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // Whitespace the decoder skips before a size; CR stays last so that
  // picking from the first five gives whitespace other than CR.
  localparam logic [7:0] SPACE_CHARS [6] = '{CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

  // Stop the run after this many cycles with no word moving on either side.
  localparam int unsigned STALL_LIMIT = 2000;
  // Bytes of body to send before winding down.
  localparam int unsigned BODY_BYTES  = 1900;

  // How the body stream ends. Errors and end of body are sticky and reset
  // comes only once, so each run picks one of these at random.
  typedef enum int {
    END_CLEAN,
    END_BAD_LEAD,
    END_BAD_AFTER_DIGITS,
    END_OVERFLOW,
    END_NO_SIZE_LF,
    END_NO_DATA_CR,
    END_NO_DATA_LF,
    END_ALL_ONES
  } ending_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  bit          gaps_on = 1'b1;
  int unsigned bytes_sent = 0;
  int unsigned stall_cycles = 0;
  int unsigned fail_count;
  int unsigned words_owed;

  hcd_in_if  body ();
  hcd_out_if result ();

  http_chunked_body_decoder i_dut (
    .clk    (clk),
    .rst    (rst),
    .body   (body),
    .result (result)
  );

  hcd_result_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .body       (body),
    .result     (result),
    .fail_count (fail_count),
    .words_owed (words_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: count cycles where no word moves on either channel.
  always @(posedge clk) begin
    if (!rst) begin
      if ((body.valid && body.ready) || (result.valid && result.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("http_chunked_body_decoder regression: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Receiver: drop ready in random bursts while gaps are on.
  initial begin : receiver
    int unsigned hold;
    hold = 0;
    result.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold != 0) begin
        hold--;
        result.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 12) - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // Any byte except the classes switched off here.
  function automatic logic [7:0] pick_byte(input bit hex_ok, input bit space_ok,
                                           input bit semi_ok, input bit cr_ok);
    logic [7:0] b;
    bit         hexy;
    bit         spacey;
    do begin
      b      = 8'($urandom_range(0, 255));
      hexy   = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66);
      spacey = (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
    end while ((!hex_ok && hexy) || (!space_ok && spacey) || (!semi_ok && b == CH_SEMI) ||
               (!cr_ok && b == CH_CR));
    return b;
  endfunction

  // Hex digit character with a random letter case.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_ZERO + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n - 4'd10);
  endfunction

  // Offer one byte. Maybe idle first; leave valid high after the handshake so
  // back-to-back bytes never drop valid between words.
  task automatic feed_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      body.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    body.valid   <= 1'b1;
    body.in_byte <= b;
    @(posedge clk);
    while (!body.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Hold off new bytes until every expected word has come back. Lower valid
  // at the step of the last handshake, then let the checker count it.
  task automatic drain();
    body.valid <= 1'b0;
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
  endtask

  task automatic send_digits(input logic [63:0] v, input int unsigned lead_zeros);
    int ndig;
    ndig = 1;
    for (int i = 1; i < 16; i++) if ((v >> (4 * i)) != 64'd0) ndig = i + 1;
    repeat (lead_zeros) feed_byte(CH_ZERO);
    for (int i = ndig - 1; i >= 0; i--) feed_byte(hex_char(4'(v >> (4 * i))));
  endtask

  // Size line with optional leading whitespace, leading zeros and extension.
  task automatic send_size_line(input logic [63:0] v);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) feed_byte(SPACE_CHARS[$urandom_range(0, 5)]);
    send_digits(v, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
    if ($urandom_range(0, 3) == 0) begin
      feed_byte(CH_SEMI);
      // Extension text runs to CR, so anything but CR may appear in it.
      repeat ($urandom_range(0, 6)) feed_byte(pick_byte(1'b1, 1'b1, 1'b1, 1'b0));
    end
    feed_byte(CH_CR);
    feed_byte(CH_LF);
  endtask

  task automatic send_payload(input int unsigned n);
    repeat (n) feed_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_chunk(input int unsigned n);
    send_size_line(64'(n));
    send_payload(n);
    feed_byte(CH_CR);
    feed_byte(CH_LF);
  endtask

  initial begin
    ending_t     ending;
    int unsigned n;
    logic [63:0] all_ones;

    body.valid   = 1'b0;
    body.in_byte = 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening: every whitespace byte before the first digit, a
    // leading zero, an uppercase letter digit, an extension holding LF,
    // then payload bytes at the extremes and bytes that look like framing.
    foreach (SPACE_CHARS[i]) feed_byte(SPACE_CHARS[i]);
    feed_byte(CH_ZERO);
    feed_byte(8'h41);
    feed_byte(CH_SEMI);
    feed_byte(CH_LF);
    feed_byte(CH_CR);
    feed_byte(CH_LF);
    feed_byte(8'h00);
    feed_byte(8'hff);
    feed_byte(CH_CR);
    feed_byte(CH_LF);
    feed_byte(CH_SEMI);
    feed_byte(CH_ZERO);
    feed_byte(8'h80);
    feed_byte(8'h7f);
    feed_byte(8'h55);
    feed_byte(8'haa);
    feed_byte(CH_CR);
    feed_byte(CH_LF);

    // Let the pipeline run dry once before the random part.
    drain();

    // Random well-formed chunks; gaps switch on and off per chunk so that
    // some stretches run flat out.
    while (bytes_sent < BODY_BYTES - 150) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      send_chunk(n);
    end

    // Last part: no idling on either side.
    gaps_on = 1'b0;
    while (bytes_sent < BODY_BYTES - 60) send_chunk($urandom_range(1, 12));

    ending   = ending_t'($urandom_range(0, 7));
    all_ones = (64'd1 << SIZE_BITS) - 64'd1;
    case (ending)
      END_CLEAN: begin
        send_size_line(64'd0);
      end
      END_BAD_LEAD: begin
        feed_byte(pick_byte(1'b0, 1'b0, 1'b1, 1'b1));
      end
      END_BAD_AFTER_DIGITS: begin
        send_digits(64'($urandom_range(1, 255)), 0);
        // Whitespace after the digits is as wrong as any other stray byte.
        if ($urandom_range(0, 1)) feed_byte(SPACE_CHARS[$urandom_range(0, 4)]);
        else feed_byte(pick_byte(1'b0, 1'b1, 1'b0, 1'b0));
      end
      END_OVERFLOW: begin
        // A nonzero lead digit and the digits after it fill the counter; the last one overflows it.
        send_digits(64'd0, $urandom_range(0, 2));
        feed_byte(hex_char(4'($urandom_range(1, 15))));
        repeat (SIZE_BITS / 4) feed_byte(hex_char(4'($urandom_range(0, 15))));
      end
      END_NO_SIZE_LF: begin
        send_digits(64'($urandom_range(1, 40)), 0);
        feed_byte(CH_CR);
        do n = $urandom_range(0, 255); while (8'(n) == CH_LF);
        feed_byte(8'(n));
      end
      END_NO_DATA_CR: begin
        n = $urandom_range(1, 8);
        send_size_line(64'(n));
        send_payload(n);
        feed_byte(pick_byte(1'b1, 1'b1, 1'b1, 1'b0));
      end
      END_NO_DATA_LF: begin
        n = $urandom_range(1, 8);
        send_size_line(64'(n));
        send_payload(n);
        feed_byte(CH_CR);
        do n = $urandom_range(0, 255); while (8'(n) == CH_LF);
        feed_byte(8'(n));
      end
      default: begin
        // Largest size that fits: accepted, then payload until the end.
        send_digits(all_ones, $urandom_range(0, 2));
        feed_byte(CH_CR);
        feed_byte(CH_LF);
      end
    endcase

    // Trailing bytes: answered "body ended" after the end, "error" after an error.
    send_payload($urandom_range(20, 40));

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("http_chunked_body_decoder regression: pass");
    end else begin
      $display("http_chunked_body_decoder regression: fail");
    end
    $finish;
  end

endmodule
